// ===== design/aprq_pkg.sv =====
`default_nettype none
package aprq_pkg;

	// Ring size and derived widths
	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// Command codes
	typedef enum logic [1:0] {
		CMD_RAISE = 2'd0,
		CMD_POP   = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_e;

	// One stored alarm entry
	typedef struct packed {
		logic [3:0]  src;
		logic [1:0]  prio;
		logic [15:0] code;
		logic [31:0] tick;
		logic        acked;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Ring index increment with wrap
	function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + IDX_W'(1);
	endfunction

endpackage
`default_nettype wire

// ===== design/aprq_req_if.sv =====
`default_nettype none
interface aprq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [3:0]  alarm_source;
	logic [1:0]  priority_req;
	logic [15:0] alarm_code;
	logic [31:0] raise_time;

	modport source (output valid, command, alarm_source, priority_req, alarm_code, raise_time,
		input ready);
	modport sink (input valid, command, alarm_source, priority_req, alarm_code, raise_time,
		output ready);
endinterface
`default_nettype wire

// ===== design/aprq_rsp_if.sv =====
`default_nettype none
interface aprq_rsp_if;
	import aprq_pkg::*;

	logic             valid;
	logic             ready;
	logic             ok;
	logic [3:0]       out_source;
	logic [1:0]       out_priority;
	logic [15:0]      out_code;
	logic [31:0]      out_time;
	logic [CNT_W-1:0] pending_count;
	logic [31:0]      raised_total;

	modport source (output valid, ok, out_source, out_priority, out_code, out_time,
		pending_count, raised_total, input ready);
	modport sink (input valid, ok, out_source, out_priority, out_code, out_time,
		pending_count, raised_total, output ready);
endinterface
`default_nettype wire

// ===== design/aprq_ram.sv =====
`default_nettype none
module aprq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== design/alarm_priority_ring_queue_unit.sv =====
// Alarm priority ring queue.
// Channels: req (sink) carries one command per transaction: raise, pop or
// clear, with the alarm fields used only by a raise. rsp (source)
// returns exactly one result per command: ok, the popped entry (zero unless a
// pop succeeded), the entries still held and the running raise total.
// Entries live in a QUEUE_DEPTH-deep entry RAM with a registered read port.
// Raise, clear and the unused code, and a pop on an empty queue, go from
// acceptance straight to the result state and then the rsp register. A pop
// walks the occupied window one RAM read per cycle, writes the winner back as
// acknowledged, then walks the head past acknowledged entries, each step a
// RAM read state followed by a check state.
// The block takes one command at a time: req.ready is high only while idle.
// A finished result sits in the rsp output register; the next command is
// accepted while it waits, and that command's result is held inside until
// the receiver takes the earlier one, so a stalled receiver loses nothing.
// Reset empties the queue and clears the raise total; the RAM needs no
// clearing because only entries inside the occupied window are ever read.
`default_nettype none
module alarm_priority_ring_queue_unit (
	input wire logic clk,
	input wire logic arst_n,
	aprq_req_if.sink   req,
	aprq_rsp_if.source rsp
);
	import aprq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MARK,
		ST_SKIP_RD,
		ST_SKIP_CHK,
		ST_RESP
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic [31:0]      total_q;

	// scan pipeline
	logic [IDX_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] left_q;
	logic             rd_v_s1;
	logic [IDX_W-1:0] addr_s1;
	logic             found_q;
	entry_t           best_q;
	logic [IDX_W-1:0] best_addr_q;

	// staged result and output register
	logic             res_ok_q;
	entry_t           res_ent_q;
	logic             rsp_valid_q;
	logic             rsp_ok_q;
	entry_t           rsp_ent_q;
	logic [CNT_W-1:0] rsp_cnt_q;
	logic [31:0]      rsp_total_q;

	// RAM port signals
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	entry_t           ram_rdata;

	logic full;
	logic req_take;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign req_take = req.valid && (state_q == ST_IDLE);

	assign req.ready = (state_q == ST_IDLE);

	// RAM access per state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = tail_q;
		ram_wdata = best_q;
		ram_re    = 1'b0;
		ram_raddr = rd_ptr_q;
		case (state_q)
			ST_IDLE: begin
				if (req_take && req.command == CMD_RAISE && !full) begin
					ram_we          = 1'b1;
					ram_waddr       = tail_q;
					ram_wdata.src   = req.alarm_source;
					ram_wdata.prio  = req.priority_req;
					ram_wdata.code  = req.alarm_code;
					ram_wdata.tick  = req.raise_time;
					ram_wdata.acked = 1'b0;
				end
			end
			ST_SCAN: begin
				ram_re    = (left_q != '0);
				ram_raddr = rd_ptr_q;
			end
			ST_MARK: begin
				ram_we          = 1'b1;
				ram_waddr       = best_addr_q;
				ram_wdata       = best_q;
				ram_wdata.acked = 1'b1;
			end
			ST_SKIP_RD: begin
				ram_re    = (count_q != '0);
				ram_raddr = head_q;
			end
			default: begin
			end
		endcase
	end

	aprq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_entry_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Command sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			total_q     <= '0;
			rd_v_s1     <= 1'b0;
			left_q      <= '0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// ST_RESP reloads the output register itself
			if (rsp_valid_q && rsp.ready && state_q != ST_RESP) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						res_ok_q  <= 1'b0;
						res_ent_q <= '0;
						state_q   <= ST_RESP;
						case (req.command)
							CMD_RAISE: begin
								if (!full) begin
									tail_q   <= idx_next(tail_q);
									count_q  <= count_q + CNT_W'(1);
									total_q  <= total_q + 32'd1;
									res_ok_q <= 1'b1;
								end
							end
							CMD_POP: begin
								if (count_q != '0) begin
									rd_ptr_q <= head_q;
									left_q   <= count_q;
									found_q  <= 1'b0;
									rd_v_s1  <= 1'b0;
									state_q  <= ST_SCAN;
								end
							end
							CMD_CLEAR: begin
								head_q   <= '0;
								tail_q   <= '0;
								count_q  <= '0;
								res_ok_q <= 1'b1;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					// issue next read
					if (left_q != '0) begin
						rd_ptr_q <= idx_next(rd_ptr_q);
						left_q   <= left_q - CNT_W'(1);
						addr_s1  <= rd_ptr_q;
						rd_v_s1  <= 1'b1;
					end else begin
						rd_v_s1 <= 1'b0;
					end
					// compare returned entry; >= lets the newest win ties
					if (rd_v_s1 && !ram_rdata.acked &&
						(!found_q || ram_rdata.prio >= best_q.prio)) begin
						found_q     <= 1'b1;
						best_q      <= ram_rdata;
						best_addr_q <= addr_s1;
					end
					if (left_q == '0 && !rd_v_s1) begin
						state_q <= found_q ? ST_MARK : ST_RESP;
					end
				end
				ST_MARK: begin
					res_ok_q  <= 1'b1;
					res_ent_q <= best_q;
					state_q   <= ST_SKIP_RD;
				end
				ST_SKIP_RD: begin
					state_q <= (count_q != '0) ? ST_SKIP_CHK : ST_RESP;
				end
				ST_SKIP_CHK: begin
					// release the head slot while it is acknowledged
					if (ram_rdata.acked) begin
						head_q  <= idx_next(head_q);
						count_q <= count_q - CNT_W'(1);
						state_q <= ST_SKIP_RD;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_ok_q    <= res_ok_q;
						rsp_ent_q   <= res_ent_q;
						rsp_cnt_q   <= count_q;
						rsp_total_q <= total_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.ok            = rsp_ok_q;
	assign rsp.out_source    = rsp_ent_q.src;
	assign rsp.out_priority  = rsp_ent_q.prio;
	assign rsp.out_code      = rsp_ent_q.code;
	assign rsp.out_time      = rsp_ent_q.tick;
	assign rsp.pending_count = rsp_cnt_q;
	assign rsp.raised_total  = rsp_total_q;

endmodule
`default_nettype wire

// ===== design/aprq_checker.sv =====
`default_nettype none
module aprq_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      rsp_valid,
	input wire logic                      rsp_ready,
	input wire logic                      rsp_ok,
	input wire logic [3:0]                rsp_src,
	input wire logic [1:0]                rsp_prio,
	input wire logic [15:0]               rsp_code,
	input wire logic [31:0]               rsp_time,
	input wire logic [aprq_pkg::CNT_W-1:0] rsp_cnt,
	input wire logic [31:0]               rsp_total
);
	import aprq_pkg::*;

	logic        seen_q;
	logic [31:0] last_total_q;

	// raise total of the previous delivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q       <= 1'b0;
			last_total_q <= '0;
		end else if (rsp_valid && rsp_ready) begin
			seen_q       <= 1'b1;
			last_total_q <= rsp_total;
		end
	end

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) && $stable(rsp_code)
			&& $stable(rsp_time) && $stable(rsp_cnt) && $stable(rsp_total))
		else $error("rsp changed while stalled");

	// occupancy never exceeds the ring
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_cnt <= CNT_W'(QUEUE_DEPTH))
		else $error("pending count beyond queue depth");

	// refused commands carry no entry
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ok |-> rsp_src == '0 && rsp_prio == '0 && rsp_code == '0
			&& rsp_time == '0)
		else $error("refused result carries entry data");

	// one command raises at most once
	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && seen_q |-> rsp_total == last_total_q
			|| rsp_total == last_total_q + 32'd1)
		else $error("raise total jumped");

endmodule

bind alarm_priority_ring_queue_unit aprq_checker u_aprq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_ok   (rsp.ok),
	.rsp_src  (rsp.out_source),
	.rsp_prio (rsp.out_priority),
	.rsp_code (rsp.out_code),
	.rsp_time (rsp.out_time),
	.rsp_cnt  (rsp.pending_count),
	.rsp_total(rsp.raised_total)
);
`default_nettype wire

// ===== sim/tb_alarm_priority_ring_queue_unit.sv =====
module tb_alarm_priority_ring_queue_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import aprq_pkg::*;

	// Command code with no function in the block
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CLK_HALF = 4;
	localparam int MAX_WAIT = 11;
	localparam int RANDOM_ITEMS = 1000;
	localparam int CHUNK_ITEMS = 40;
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 80;

	// One result as the block should report it
	typedef struct packed {
		logic             ok;
		logic [3:0]       src;
		logic [1:0]       prio;
		logic [15:0]      code;
		logic [31:0]      tick;
		logic [CNT_W-1:0] pending;
		logic [31:0]      total;
	} alarm_result_t;

	logic clk;
	logic arst_n;

	aprq_req_if req_ch ();
	aprq_rsp_if rsp_ch ();

	alarm_priority_ring_queue_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Predicted queue contents
	entry_t            alarm_ring [QUEUE_DEPTH];
	logic [IDX_W-1:0]  ring_head;
	logic [IDX_W-1:0]  ring_tail;
	int                held_count;
	logic [31:0]       raise_tally;

	alarm_result_t awaited_results [$];
	int  mismatches;
	bit  steady;
	int  idle_cycles;
	int  n_raised, n_refused, n_popped, n_empty_pops, n_clears, n_unused;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Apply one command to the predicted queue, return the expected result
	function automatic alarm_result_t apply_command(input logic [1:0] command,
		input logic [3:0] src, input logic [1:0] prio, input logic [15:0] code,
		input logic [31:0] tick);
		alarm_result_t r;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] best;
		logic [1:0] top_prio;
		bit found;
		int i;
		r = '0;
		case (command)
			CMD_RAISE: begin
				if (held_count < QUEUE_DEPTH) begin
					alarm_ring[ring_tail] = '{src: src, prio: prio, code: code,
						tick: tick, acked: 1'b0};
					ring_tail = IDX_W'((ring_tail + 1) % QUEUE_DEPTH);
					held_count++;
					raise_tally++;
					r.ok = 1'b1;
				end
			end
			CMD_POP: begin
				// newest unacknowledged entry of highest priority wins
				idx = ring_head;
				best = '0;
				top_prio = '0;
				found = 1'b0;
				for (i = 0; i < held_count; i++) begin
					if (!alarm_ring[idx].acked && alarm_ring[idx].prio >= top_prio) begin
						top_prio = alarm_ring[idx].prio;
						best = idx;
						found = 1'b1;
					end
					idx = IDX_W'((idx + 1) % QUEUE_DEPTH);
				end
				if (found) begin
					r.ok = 1'b1;
					r.src = alarm_ring[best].src;
					r.prio = alarm_ring[best].prio;
					r.code = alarm_ring[best].code;
					r.tick = alarm_ring[best].tick;
					alarm_ring[best].acked = 1'b1;
					// release acknowledged slots at the head
					while (held_count > 0 && alarm_ring[ring_head].acked) begin
						ring_head = IDX_W'((ring_head + 1) % QUEUE_DEPTH);
						held_count--;
					end
				end
			end
			CMD_CLEAR: begin
				for (i = 0; i < QUEUE_DEPTH; i++)
					alarm_ring[i].acked = 1'b1;
				ring_head = '0;
				ring_tail = '0;
				held_count = 0;
				r.ok = 1'b1;
			end
			default: ;
		endcase
		r.pending = CNT_W'(held_count);
		r.total = raise_tally;
		return r;
	endfunction

	// Drive one command and wait for its transaction
	task automatic send_command(input logic [1:0] command, input logic [3:0] src,
		input logic [1:0] prio, input logic [15:0] code, input logic [31:0] tick);
		int gap;
		alarm_result_t predicted;
		gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			// junk on the payload while idle
			req_ch.valid <= 1'b0;
			req_ch.command <= 2'($urandom);
			req_ch.alarm_source <= 4'($urandom);
			req_ch.priority_req <= 2'($urandom);
			req_ch.alarm_code <= 16'($urandom);
			req_ch.raise_time <= $urandom;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= command;
		req_ch.alarm_source <= src;
		req_ch.priority_req <= prio;
		req_ch.alarm_code <= code;
		req_ch.raise_time <= tick;
		do @(posedge clk); while (!req_ch.ready);
		predicted = apply_command(command, src, prio, code, tick);
		awaited_results.push_back(predicted);
		case (command)
			CMD_RAISE: if (predicted.ok) n_raised++; else n_refused++;
			CMD_POP:   if (predicted.ok) n_popped++; else n_empty_pops++;
			CMD_CLEAR: n_clears++;
			default:   n_unused++;
		endcase
	endtask

	task automatic raise_alarm(input logic [3:0] src, input logic [1:0] prio,
		input logic [15:0] code, input logic [31:0] tick);
		send_command(CMD_RAISE, src, prio, code, tick);
	endtask

	// non-raise commands carry random fields that must be ignored
	task automatic send_bare(input logic [1:0] command);
		send_command(command, 4'($urandom), 2'($urandom), 16'($urandom), $urandom);
	endtask

	// Pop, unused code and clear on an empty queue
	task automatic test_empty_queue();
		send_bare(CMD_POP);
		send_bare(CMD_UNUSED);
		send_bare(CMD_CLEAR);
	endtask

	// Field extremes, tie order and head skipping over acknowledged entries
	task automatic test_field_extremes();
		raise_alarm(4'h0, 2'd0, 16'h0000, 32'h0000_0000);
		raise_alarm(4'hF, 2'd3, 16'hFFFF, 32'hFFFF_FFFF);
		raise_alarm(4'hA, 2'd3, 16'h5A5A, 32'h8000_0001);
		raise_alarm(4'h5, 2'd1, 16'hA5A5, 32'h7FFF_FFFE);
		// newer priority 3 first, then older priority 3, then priority 1
		send_bare(CMD_POP);
		send_bare(CMD_POP);
		send_bare(CMD_POP);
		// oldest goes last and the whole window is released
		send_bare(CMD_POP);
	endtask

	// Fill to the top, refuse one more, then pop from the full queue and clear
	task automatic test_full_refusal();
		while (held_count < QUEUE_DEPTH)
			raise_alarm(4'($urandom), 2'($urandom), 16'($urandom), $urandom);
		raise_alarm(4'($urandom), 2'($urandom), 16'($urandom), $urandom);
		send_bare(CMD_POP);
		send_bare(CMD_CLEAR);
	endtask

	// Mixed traffic in chunks that lean toward filling or draining
	task automatic test_random_traffic();
		int issued;
		int k;
		int pick;
		int raise_pct;
		issued = 0;
		while (issued < RANDOM_ITEMS) begin
			raise_pct = ($urandom_range(0, 1) == 0) ? 72 : 30;
			steady = ($urandom_range(0, 3) == 0);
			for (k = 0; k < CHUNK_ITEMS; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 2) begin
					send_bare(CMD_CLEAR);
					issued++;
				end else if (pick < 4) begin
					send_bare(CMD_UNUSED);
				end else if (pick < raise_pct) begin
					raise_alarm(4'($urandom), 2'($urandom), 16'($urandom), $urandom);
					issued++;
				end else begin
					send_bare(CMD_POP);
					issued++;
				end
			end
		end
		steady = 1'b0;
	endtask

	// Result receiver with random stalls
	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	task automatic check_field(input string name, input logic [31:0] exp_val,
		input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			mismatches++;
			$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, name, exp_val, act_val);
		end
	endtask

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		alarm_result_t exp_r;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_results.size() == 0) begin
				mismatches++;
				$display("%0t ns: unexpected result, expected none, actual ok=%0b pending=%0d",
					$time, rsp_ch.ok, rsp_ch.pending_count);
			end else begin
				exp_r = awaited_results.pop_front();
				check_field("ok", exp_r.ok, rsp_ch.ok);
				check_field("out_source", exp_r.src, rsp_ch.out_source);
				check_field("out_priority", exp_r.prio, rsp_ch.out_priority);
				check_field("out_code", exp_r.code, rsp_ch.out_code);
				check_field("out_time", exp_r.tick, rsp_ch.out_time);
				check_field("pending_count", exp_r.pending, rsp_ch.pending_count);
				check_field("raised_total", exp_r.total, rsp_ch.raised_total);
			end
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles <= 0;
			else if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// Reset, test sequence and final verdict
	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_RAISE;
		req_ch.alarm_source = '0;
		req_ch.priority_req = '0;
		req_ch.alarm_code = '0;
		req_ch.raise_time = '0;
		steady = 1'b0;
		idle_cycles = 0;
		mismatches = 0;
		n_raised = 0;
		n_refused = 0;
		n_popped = 0;
		n_empty_pops = 0;
		n_clears = 0;
		n_unused = 0;
		ring_head = '0;
		ring_tail = '0;
		held_count = 0;
		raise_tally = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++)
			alarm_ring[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		test_field_extremes();
		test_full_refusal();
		test_random_traffic();
		req_ch.valid <= 1'b0;

		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Raises accepted %0d, refused when full %0d, clears %0d, unused codes %0d",
			n_raised, n_refused, n_clears, n_unused);
		$display("Pops returning an entry %0d, pops on an empty queue %0d, mismatches %0d",
			n_popped, n_empty_pops, mismatches);
		if (mismatches == 0 && awaited_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
